// ===== src/ber_tlv_stream_parser_assert.svh =====
// Assertion macros shared by the BER-TLV stream parser RTL.
`ifndef BER_TLV_STREAM_PARSER_ASSERT_SVH
`define BER_TLV_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define BTLV_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset
`define BTLV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/btlv_pkg.sv =====
// Shared types and constants for the BER-TLV stream parser.
`default_nettype none

package btlv_pkg;

  // Byte labels
  localparam logic [2:0] KIND_PAD = 3'd0;
  localparam logic [2:0] KIND_TAG = 3'd1;
  localparam logic [2:0] KIND_LEN = 3'd2;
  localparam logic [2:0] KIND_VAL = 3'd3;
  localparam logic [2:0] KIND_IGN = 3'd4;

  // End status codes
  localparam logic [1:0] STATUS_CLEAN     = 2'd0;
  localparam logic [1:0] STATUS_HDR_SHORT = 2'd1;
  localparam logic [1:0] STATUS_VAL_SHORT = 2'd2;
  localparam logic [1:0] STATUS_BAD_LEN   = 2'd3;

  // Special byte values
  localparam logic [7:0] PAD_BYTE  = 8'h00;
  localparam logic [7:0] LEN_LONG  = 8'h80;
  localparam logic [7:0] LEN_FORM1 = 8'h81;
  localparam logic [7:0] LEN_FORM2 = 8'h82;

  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_LEN    = 7'b0000010,
    PH_LEN81  = 7'b0000100,
    PH_LEN82H = 7'b0001000,
    PH_LEN82L = 7'b0010000,
    PH_VALUE  = 7'b0100000,
    PH_STOP   = 7'b1000000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  current_tag;
    logic [15:0] value_length;
    logic [15:0] value_count;
    logic [1:0]  stop_reason;
  } state_t;

  typedef struct packed {
    logic [2:0]  byte_kind;
    logic [7:0]  object_tag;
    logic [7:0]  echoed_byte;
    logic [15:0] value_index;
    logic [15:0] declared_length;
    logic        object_done;
    logic        message_end;
    logic [1:0]  end_status;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase:        PH_IDLE,
    current_tag:  8'h00,
    value_length: 16'h0000,
    value_count:  16'h0000,
    stop_reason:  STATUS_CLEAN
  };

endpackage

`default_nettype wire

// ===== src/btlv_step.sv =====
// Per-byte parse step: next parser state and the labelled result word.
`default_nettype none

module btlv_step (
  input  wire btlv_pkg::state_t  state,
  input  wire logic [7:0]        body_byte,
  input  wire logic              is_last,
  output btlv_pkg::state_t       state_next,
  output btlv_pkg::result_t      result
);

  always_comb begin
    logic [15:0] len;
    logic [15:0] count_inc;
    btlv_pkg::state_t st;
    btlv_pkg::result_t res;

    st = state;
    len = 16'h0000;
    count_inc = state.value_count + 16'd1;
    res.byte_kind       = btlv_pkg::KIND_IGN;
    res.object_tag      = 8'h00;
    res.echoed_byte     = body_byte;
    res.value_index     = 16'h0000;
    res.declared_length = 16'h0000;
    res.object_done     = 1'b0;
    res.message_end     = is_last;
    res.end_status      = btlv_pkg::STATUS_CLEAN;

    // Phase dispatch
    case (state.phase)
      btlv_pkg::PH_IDLE: begin
        if (body_byte == btlv_pkg::PAD_BYTE) begin
          res.byte_kind = btlv_pkg::KIND_PAD;
        end else begin
          res.byte_kind  = btlv_pkg::KIND_TAG;
          res.object_tag = body_byte;
          st.current_tag = body_byte;
          st.phase       = btlv_pkg::PH_LEN;
        end
      end
      btlv_pkg::PH_LEN: begin
        res.byte_kind  = btlv_pkg::KIND_LEN;
        res.object_tag = state.current_tag;
        if (body_byte < btlv_pkg::LEN_LONG) begin
          len = {8'h00, body_byte};
          st.value_length = len;
          st.value_count  = 16'h0000;
          res.declared_length = len;
          if (len == 16'h0000) begin
            res.object_done = 1'b1;
            st.phase = btlv_pkg::PH_IDLE;
          end else begin
            st.phase = btlv_pkg::PH_VALUE;
          end
        end else if (body_byte == btlv_pkg::LEN_FORM1) begin
          st.phase = btlv_pkg::PH_LEN81;
        end else if (body_byte == btlv_pkg::LEN_FORM2) begin
          st.phase = btlv_pkg::PH_LEN82H;
        end else begin
          st.stop_reason = btlv_pkg::STATUS_BAD_LEN;
          st.phase       = btlv_pkg::PH_STOP;
        end
      end
      btlv_pkg::PH_LEN81, btlv_pkg::PH_LEN82L: begin
        res.byte_kind  = btlv_pkg::KIND_LEN;
        res.object_tag = state.current_tag;
        // long forms: one byte, or high byte already held
        len = (state.phase == btlv_pkg::PH_LEN81) ? {8'h00, body_byte}
                                                  : {state.value_length[15:8], body_byte};
        st.value_length = len;
        st.value_count  = 16'h0000;
        res.declared_length = len;
        if (len == 16'h0000) begin
          res.object_done = 1'b1;
          st.phase = btlv_pkg::PH_IDLE;
        end else begin
          st.phase = btlv_pkg::PH_VALUE;
        end
      end
      btlv_pkg::PH_LEN82H: begin
        res.byte_kind   = btlv_pkg::KIND_LEN;
        res.object_tag  = state.current_tag;
        st.value_length = {body_byte, 8'h00};
        st.phase        = btlv_pkg::PH_LEN82L;
      end
      btlv_pkg::PH_VALUE: begin
        res.byte_kind       = btlv_pkg::KIND_VAL;
        res.object_tag      = state.current_tag;
        res.declared_length = state.value_length;
        res.value_index     = state.value_count;
        st.value_count      = count_inc;
        if (count_inc >= state.value_length) begin
          res.object_done = 1'b1;
          st.phase = btlv_pkg::PH_IDLE;
        end
      end
      default: begin
        res.byte_kind = btlv_pkg::KIND_IGN;
        st.phase      = btlv_pkg::PH_STOP;
      end
    endcase

    // Message end: report status, then back to reset state
    if (is_last) begin
      if (st.phase == btlv_pkg::PH_STOP) begin
        res.end_status = btlv_pkg::STATUS_BAD_LEN;
      end else if (st.phase == btlv_pkg::PH_VALUE) begin
        res.end_status = btlv_pkg::STATUS_VAL_SHORT;
      end else if (st.phase != btlv_pkg::PH_IDLE) begin
        res.end_status = btlv_pkg::STATUS_HDR_SHORT;
      end else begin
        res.end_status = btlv_pkg::STATUS_CLEAN;
      end
      st = btlv_pkg::STATE_RESET;
    end

    state_next = st;
    result     = res;
  end

endmodule

`default_nettype wire

// ===== src/ber_tlv_stream_parser.sv =====
// An input word passes the input register, then the result register, to the outputs.
// Throughput: one word per cycle; the input register feeds the parse step and the
// parser state and result register update together, so only out_stall makes bytes wait.
// Stall propagates from the output only when both register stages are full.
// Reset (rst, synchronous, active high) empties both stages and returns the parser
// to expecting a tag or padding.
`default_nettype none

`include "ber_tlv_stream_parser_assert.svh"

module ber_tlv_stream_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  body_byte,
  input  wire logic        is_last,
  // output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       byte_kind,
  output logic [7:0]       object_tag,
  output logic [7:0]       echoed_byte,
  output logic [15:0]      value_index,
  output logic [15:0]      declared_length,
  output logic             object_done,
  output logic             message_end,
  output logic [1:0]       end_status
);

  logic              in_reg_valid;
  logic [7:0]        in_reg_byte;
  logic              in_reg_last;
  logic              res_valid;
  btlv_pkg::result_t res;
  btlv_pkg::state_t  state;
  btlv_pkg::state_t  state_next;
  btlv_pkg::result_t res_next;
  logic              res_adv;
  logic              parse_fire;

  // Pipeline advance
  assign res_adv    = !res_valid || !out_stall;
  assign parse_fire = in_reg_valid && res_adv;
  assign in_stall   = in_reg_valid && !res_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      in_reg_byte <= body_byte;
      in_reg_last <= is_last;
    end
  end

  btlv_step u_step (
    .state      (state),
    .body_byte  (in_reg_byte),
    .is_last    (in_reg_last),
    .state_next (state_next),
    .result     (res_next)
  );

  // Parser state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= btlv_pkg::STATE_RESET;
      res_valid <= 1'b0;
    end else begin
      if (parse_fire) begin
        state <= state_next;
      end
      if (res_adv) begin
        res_valid <= in_reg_valid;
      end
    end
    if (parse_fire) begin
      res <= res_next;
    end
  end

  assign out_valid       = res_valid;
  assign byte_kind       = res.byte_kind;
  assign object_tag      = res.object_tag;
  assign echoed_byte     = res.echoed_byte;
  assign value_index     = res.value_index;
  assign declared_length = res.declared_length;
  assign object_done     = res.object_done;
  assign message_end     = res.message_end;
  assign end_status      = res.end_status;

  // Checks
  `BTLV_ASSERT_NOW(a_stall_only_when_full, clk, rst,
    in_stall, res_valid && out_stall && in_reg_valid)
  `BTLV_ASSERT_NOW(a_status_only_at_end, clk, rst,
    res_valid && (res.end_status != btlv_pkg::STATUS_CLEAN), res.message_end)
  `BTLV_ASSERT_NOW(a_stop_has_reason, clk, rst,
    state.phase == btlv_pkg::PH_STOP, state.stop_reason == btlv_pkg::STATUS_BAD_LEN)
  `BTLV_ASSERT_NEXT(a_reset_after_last, clk, rst,
    parse_fire && in_reg_last, state == btlv_pkg::STATE_RESET)

endmodule

`default_nettype wire

// ===== tb/ber_tlv_word_checker.sv =====
// Watches both channels of the BER-TLV stream parser, predicts each result word and compares.
`timescale 1ns / 1ps

module ber_tlv_word_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  body_byte,
  input  wire logic        is_last,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [2:0]  byte_kind,
  input  wire logic [7:0]  object_tag,
  input  wire logic [7:0]  echoed_byte,
  input  wire logic [15:0] value_index,
  input  wire logic [15:0] declared_length,
  input  wire logic        object_done,
  input  wire logic        message_end,
  input  wire logic [1:0]  end_status,
  output int               mismatches,
  output int               outstanding
);

  // Parser state as the words go in
  btlv_pkg::phase_t ph;
  logic [7:0]       tag_r;
  logic [15:0]      len_r;
  logic [15:0]      cnt_r;

  btlv_pkg::result_t expected_q[$];
  int                err_count = 0;

  // Label one input byte and advance the parse state
  function automatic btlv_pkg::result_t parse_word(input logic [7:0] b, input logic last);
    btlv_pkg::result_t r;
    logic              have_len;
    logic [15:0]       new_len;
    r             = '0;
    r.byte_kind   = btlv_pkg::KIND_IGN;
    r.echoed_byte = b;
    r.message_end = last;
    have_len      = 1'b0;
    new_len       = '0;
    case (ph)
      btlv_pkg::PH_IDLE: begin
        if (b == btlv_pkg::PAD_BYTE) begin
          r.byte_kind = btlv_pkg::KIND_PAD;
        end else begin
          r.byte_kind  = btlv_pkg::KIND_TAG;
          r.object_tag = b;
          tag_r        = b;
          ph           = btlv_pkg::PH_LEN;
        end
      end
      btlv_pkg::PH_LEN: begin
        r.byte_kind  = btlv_pkg::KIND_LEN;
        r.object_tag = tag_r;
        if (b < btlv_pkg::LEN_LONG) begin
          have_len = 1'b1;
          new_len  = {8'h00, b};
        end else if (b == btlv_pkg::LEN_FORM1) begin
          ph = btlv_pkg::PH_LEN81;
        end else if (b == btlv_pkg::LEN_FORM2) begin
          ph = btlv_pkg::PH_LEN82H;
        end else begin
          // 0x80 and 0x83 up: nothing more is parsed in this message
          ph = btlv_pkg::PH_STOP;
        end
      end
      btlv_pkg::PH_LEN81: begin
        r.byte_kind  = btlv_pkg::KIND_LEN;
        r.object_tag = tag_r;
        have_len     = 1'b1;
        new_len      = {8'h00, b};
      end
      btlv_pkg::PH_LEN82H: begin
        r.byte_kind  = btlv_pkg::KIND_LEN;
        r.object_tag = tag_r;
        len_r        = {b, 8'h00};
        ph           = btlv_pkg::PH_LEN82L;
      end
      btlv_pkg::PH_LEN82L: begin
        r.byte_kind  = btlv_pkg::KIND_LEN;
        r.object_tag = tag_r;
        have_len     = 1'b1;
        new_len      = {len_r[15:8], b};
      end
      btlv_pkg::PH_VALUE: begin
        r.byte_kind       = btlv_pkg::KIND_VAL;
        r.object_tag      = tag_r;
        r.declared_length = len_r;
        r.value_index     = cnt_r;
        cnt_r             = cnt_r + 16'd1;
        if (cnt_r >= len_r) begin
          r.object_done = 1'b1;
          ph            = btlv_pkg::PH_IDLE;
        end
      end
      default: begin
        ph = btlv_pkg::PH_STOP;
      end
    endcase

    // Final length byte: zero length closes the object right here
    if (have_len) begin
      len_r             = new_len;
      cnt_r             = '0;
      r.declared_length = new_len;
      if (new_len == 16'd0) begin
        r.object_done = 1'b1;
        ph            = btlv_pkg::PH_IDLE;
      end else begin
        ph = btlv_pkg::PH_VALUE;
      end
    end

    // End of message: report where the parse stood, then start over
    if (last) begin
      if (ph == btlv_pkg::PH_STOP)       r.end_status = btlv_pkg::STATUS_BAD_LEN;
      else if (ph == btlv_pkg::PH_VALUE) r.end_status = btlv_pkg::STATUS_VAL_SHORT;
      else if (ph != btlv_pkg::PH_IDLE)  r.end_status = btlv_pkg::STATUS_HDR_SHORT;
      else                               r.end_status = btlv_pkg::STATUS_CLEAN;
      ph    = btlv_pkg::PH_IDLE;
      tag_r = '0;
      len_r = '0;
      cnt_r = '0;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      err_count++;
    end
  endtask

  // Predict on input words, compare on output words
  always @(posedge clk) begin : track
    btlv_pkg::result_t want;
    if (rst) begin
      ph    = btlv_pkg::PH_IDLE;
      tag_r = '0;
      len_r = '0;
      cnt_r = '0;
      expected_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        expected_q.insert(expected_q.size(), parse_word(body_byte, is_last));
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result word with none expected, expected nothing, actual byte %02h",
                   $time, echoed_byte);
          err_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("byte_kind", 32'(want.byte_kind), 32'(byte_kind));
          check_field("object_tag", 32'(want.object_tag), 32'(object_tag));
          check_field("echoed_byte", 32'(want.echoed_byte), 32'(echoed_byte));
          check_field("value_index", 32'(want.value_index), 32'(value_index));
          check_field("declared_length", 32'(want.declared_length),
                      32'(declared_length));
          check_field("object_done", 32'(want.object_done), 32'(object_done));
          check_field("message_end", 32'(want.message_end), 32'(message_end));
          check_field("end_status", 32'(want.end_status), 32'(end_status));
        end
      end
    end
    mismatches  <= err_count;
    outstanding <= expected_q.size();
  end

endmodule

// ===== tb/tb_ber_tlv_stream_parser.sv =====
// Top of the BER-TLV stream parser testbench: clock, reset, message stimulus and verdict.
`timescale 1ns / 1ps

module tb_ber_tlv_stream_parser;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  body_byte;
  logic        is_last;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  byte_kind;
  logic [7:0]  object_tag;
  logic [7:0]  echoed_byte;
  logic [15:0] value_index;
  logic [15:0] declared_length;
  logic        object_done;
  logic        message_end;
  logic [1:0]  end_status;
  int          mismatches;
  int          outstanding;

  int         send_idle_pct = 36;
  int         recv_idle_pct = 68;
  bit         hold_req = 1'b0;
  int         words_sent = 0;
  logic [7:0] msg_bytes[$];

  ber_tlv_stream_parser DUT (.*);

  ber_tlv_word_checker word_check (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Give up well past the slowest legal run
  initial begin
    #2_000_000;
    $display("FAIL ber_tlv_stream_parser");
    $finish;
  end

  // Receiver: random stalls, or one long hold-off when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      if (hold_req) begin
        repeat (300) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
        hold_req = 1'b0;
      end else begin
        @(negedge clk);
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // One word on the input channel, with random idle cycles ahead of it
  task automatic send_word(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    body_byte <= b;
    is_last   <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic send_message();
    foreach (msg_bytes[i]) send_word(msg_bytes[i], i == msg_bytes.size() - 1);
  endtask

  // Add one byte at the tail of the message being built
  function automatic void append_byte(input logic [7:0] b);
    msg_bytes.insert(msg_bytes.size(), b);
  endfunction

  // Mostly well-formed objects with random content; some noise and broken messages
  function automatic void make_message();
    int sel;
    int objs;
    int vlen;
    int form;
    int k;
    sel = $urandom_range(99);
    msg_bytes.delete();
    if (sel < 8) begin
      k = $urandom_range(1, 8);
      repeat (k) append_byte(8'($urandom));
    end else begin
      objs = $urandom_range(3);
      repeat (objs) begin
        if ($urandom_range(3) == 0) begin
          repeat ($urandom_range(1, 2)) append_byte(btlv_pkg::PAD_BYTE);
        end
        append_byte(8'($urandom_range(1, 255)));
        vlen = ($urandom_range(9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 4);
        form = $urandom_range(2);
        if (form == 1) begin
          append_byte(btlv_pkg::LEN_FORM1);
        end else if (form == 2) begin
          append_byte(btlv_pkg::LEN_FORM2);
          append_byte(8'h00);
        end
        append_byte(8'(vlen));
        repeat (vlen) append_byte(8'($urandom));
      end
      if (sel < 16) begin
        // unsupported length form, then a tail that gets ignored
        append_byte(8'($urandom_range(1, 255)));
        append_byte(($urandom_range(3) == 0) ? btlv_pkg::LEN_LONG
                                             : 8'($urandom_range(8'h83, 8'hFF)));
        repeat ($urandom_range(0, 4)) append_byte(8'($urandom));
      end else if (sel < 22) begin
        // two-byte length with random bytes, then a short random tail
        append_byte(8'($urandom_range(1, 255)));
        append_byte(btlv_pkg::LEN_FORM2);
        append_byte(8'($urandom));
        append_byte(8'($urandom));
        repeat ($urandom_range(0, 3)) append_byte(8'($urandom));
      end else if (sel < 30 && msg_bytes.size() > 1) begin
        // cut short at a random point
        k = $urandom_range(1, msg_bytes.size() - 1);
        while (msg_bytes.size() > k) void'(msg_bytes.pop_back());
      end
      if ($urandom_range(4) == 0) append_byte(btlv_pkg::PAD_BYTE);
      if (msg_bytes.size() == 0) append_byte(btlv_pkg::PAD_BYTE);
    end
  endfunction

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    body_byte = 8'h00;
    is_last   = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // padding only
    msg_bytes = '{btlv_pkg::PAD_BYTE};
    send_message();
    // zero length, short form
    msg_bytes = '{8'hFF, 8'h00};
    send_message();
    // zero length in the one-byte and two-byte long forms
    msg_bytes = '{8'h01, btlv_pkg::LEN_FORM1, 8'h00, 8'h02, btlv_pkg::LEN_FORM2,
                  8'h00, 8'h00};
    send_message();
    // one value byte
    msg_bytes = '{8'h7E, btlv_pkg::LEN_FORM1, 8'h01, 8'hFF};
    send_message();
    // 0x80 length form stops the parse, tail ignored
    msg_bytes = '{8'h55, btlv_pkg::LEN_LONG, 8'hAA};
    send_message();
    // bad length form on the final byte
    msg_bytes = '{8'h66, 8'hFF};
    send_message();
    // message ends right after a tag
    msg_bytes = '{8'h10};
    send_message();
    // largest length, value cut short
    msg_bytes = '{8'h11, btlv_pkg::LEN_FORM2, 8'hFF, 8'hFF, 8'h00};
    send_message();

    while (words_sent < 190) begin
      make_message();
      send_message();
    end
    send_idle_pct = 68;
    recv_idle_pct = 36;
    while (words_sent < 350) begin
      make_message();
      send_message();
    end
    // no idling; a long receiver hold-off backs the block up to its input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    while (words_sent < 520) begin
      make_message();
      send_message();
    end
    in_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS ber_tlv_stream_parser");
    end else begin
      $display("FAIL ber_tlv_stream_parser");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/btlv_pkg.sv
src/btlv_step.sv
src/ber_tlv_stream_parser.sv
tb/ber_tlv_word_checker.sv
tb/tb_ber_tlv_stream_parser.sv
